### design/xcfr_pkg.sv
`timescale 1ns / 1ps

package xcfr_pkg;

    localparam int RECV_DEPTH             = 256;
    localparam int MIN_BYTES_BEFORE_CHECK = 5;

    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 3;
    localparam int LEN_W  = 16;
    localparam int CNT_W  = $clog2(RECV_DEPTH + 1);
    localparam int IDX_W  = $clog2(RECV_DEPTH);
    localparam int HLEN_W = CNT_W;

    // power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h7E;

    localparam logic [OP_W-1:0] OP_RX      = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    typedef enum logic [ST_W-1:0] {
        ST_PROGRESS   = 3'd0,
        ST_HDR_REJECT = 3'd1,
        ST_ACCEPTED   = 3'd2,
        ST_CSUM_BAD   = 3'd3,
        ST_DROP_BUSY  = 3'd4,
        ST_OVERFLOW   = 3'd5,
        ST_RELEASED   = 3'd6,
        ST_READ       = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CMD_RX,
        CMD_RELEASE,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic [IDX_W-1:0]   index;
        logic               index_ok;
    } cmd_t;

endpackage

### design/xcfr_front.sv
`timescale 1ns / 1ps

module xcfr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [xcfr_pkg::OP_W-1:0]   opcode,
    input  logic [xcfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [7:0]                  read_index,
    output logic                        head_valid,
    output xcfr_pkg::cmd_t              head,
    input  logic                        pop
);
    import xcfr_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   fill_reg, fill_next;
    logic              push;
    cmd_t              cls;

    // classify the incoming word
    always_comb
    begin
        cls.data     = rx_byte;
        cls.index    = read_index[IDX_W-1:0];
        cls.index_ok = (int'(read_index) < RECV_DEPTH);
        unique case (opcode)
            OP_RX:      cls.kind = CMD_RX;
            OP_RELEASE: cls.kind = CMD_RELEASE;
            OP_READ:    cls.kind = CMD_READ;
            OP_NOP:     cls.kind = CMD_NOP;
        endcase
    end

    assign in_ready   = (fill_reg != QC_W'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (fill_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QP_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QP_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + QC_W'(1);
            2'b01:   fill_next = fill_reg - QC_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QC_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> fill_reg != '0)
        else $error("pushed word not queued");

endmodule

### design/xcfr_back.sv
`timescale 1ns / 1ps

module xcfr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  xcfr_pkg::cmd_t              head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [xcfr_pkg::ST_W-1:0]   status,
    output logic [xcfr_pkg::HLEN_W-1:0] held_length,
    output logic                        frame_pending,
    output logic [xcfr_pkg::BYTE_W-1:0] read_data
);
    import xcfr_pkg::*;

    localparam int LX_W = LEN_W + 1;
    localparam int EX_N = MIN_BYTES_BEFORE_CHECK - 1;
    localparam int EX_W = $clog2(EX_N);

    // two banks; own_reg[i] picks the bank holding held byte i, the other
    // bank takes incoming bytes at i, so a good frame is "copied" by flipping
    logic [BYTE_W-1:0]     mem_a [RECV_DEPTH];
    logic [BYTE_W-1:0]     mem_b [RECV_DEPTH];
    logic [BYTE_W-1:0]     rd_a_reg, rd_b_reg;
    logic [RECV_DEPTH-1:0] own_reg, own_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_new;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  pend_reg, pend_next;
    logic [CNT_W-1:0]      hcnt_reg, hcnt_next;
    logic [BYTE_W-1:0]     xacc_reg, xacc_next;
    logic [BYTE_W-1:0]     ex_reg [EX_N];
    logic [BYTE_W-1:0]     csum;

    logic [IDX_W-1:0]      pos;
    logic                  exec, is_rx, is_read, flip, ex_wr;
    logic                  wr_a, wr_b;
    status_t               st;

    logic                  s1_valid_reg;
    status_t               s1_status_reg;
    logic [CNT_W-1:0]      s1_hlen_reg;
    logic                  s1_pend_reg;
    logic                  s1_read_reg;
    logic                  s1_sel_reg;

    assign exec    = head_valid && (!s1_valid_reg || out_ready);
    assign pop     = exec;
    assign is_rx   = exec && (head.kind == CMD_RX);
    assign is_read = exec && (head.kind == CMD_READ);
    assign pos     = cnt_reg[IDX_W-1:0];
    assign cnt_new = cnt_reg + CNT_W'(1);
    assign wr_a    = is_rx && own_reg[pos];
    assign wr_b    = is_rx && !own_reg[pos];
    assign ex_wr   = is_rx && (pos != '0) && (int'(pos) <= EX_N);

    // short frames are checked before the running XOR has caught up
    assign csum = (len_reg <= LEN_W'(MIN_BYTES_BEFORE_CHECK - 2))
                ? ex_reg[len_reg[EX_W-1:0]] : xacc_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        pend_next = pend_reg;
        hcnt_next = hcnt_reg;
        xacc_next = xacc_reg;
        flip      = 1'b0;
        st        = ST_PROGRESS;
        if (exec)
        begin
            unique case (head.kind)
                CMD_RX:
                begin
                    cnt_next  = cnt_new;
                    xacc_next = (pos < IDX_W'(2)) ? '0 : (xacc_reg ^ head.data);
                    if (cnt_new == CNT_W'(1) || cnt_new == CNT_W'(2))
                    begin
                        if (head.data != SYNC_BYTE)
                        begin
                            cnt_next = '0;
                            st       = ST_HDR_REJECT;
                        end
                    end
                    else if (cnt_new == CNT_W'(3))
                    begin
                        len_next[LEN_W-1:BYTE_W] = head.data;
                    end
                    else if (cnt_new == CNT_W'(4))
                    begin
                        len_next[BYTE_W-1:0] = head.data;
                    end
                    else if (cnt_new != CNT_W'(5))
                    begin
                        if (cnt_new > CNT_W'(MIN_BYTES_BEFORE_CHECK) &&
                            LX_W'(cnt_new) >= LX_W'(len_reg) + LX_W'(3))
                        begin
                            if (csum == head.data)
                            begin
                                if (!pend_reg)
                                begin
                                    pend_next = 1'b1;
                                    hcnt_next = cnt_new;
                                    flip      = 1'b1;
                                    st        = ST_ACCEPTED;
                                end
                                else
                                begin
                                    st = ST_DROP_BUSY;
                                end
                            end
                            else
                            begin
                                st = ST_CSUM_BAD;
                            end
                            cnt_next = '0;
                        end
                        if (int'(cnt_next) >= RECV_DEPTH)
                        begin
                            cnt_next = '0;
                            st       = ST_OVERFLOW;
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    pend_next = 1'b0;
                    st        = ST_RELEASED;
                end
                CMD_READ:    st = ST_READ;
                CMD_NOP:     st = ST_PROGRESS;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < RECV_DEPTH; i++)
        begin
            own_next[i] = own_reg[i] ^ (flip && (CNT_W'(i) < cnt_new));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            len_reg      <= '0;
            pend_reg     <= 1'b0;
            hcnt_reg     <= '0;
            own_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            pend_reg <= pend_next;
            hcnt_reg <= hcnt_next;
            own_reg  <= own_next;
            if (exec)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xacc_reg <= xacc_next;
        if (ex_wr)
        begin
            ex_reg[EX_W'(pos - IDX_W'(1))] <= (pos == IDX_W'(1)) ? '0 : (xacc_reg ^ head.data);
        end
        if (exec)
        begin
            s1_status_reg <= st;
            s1_hlen_reg   <= hcnt_next;
            s1_pend_reg   <= pend_next;
            s1_read_reg   <= (head.kind == CMD_READ) && head.index_ok;
            s1_sel_reg    <= own_reg[head.index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[pos] <= head.data;
        end
        if (is_read)
        begin
            rd_a_reg <= mem_a[head.index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[pos] <= head.data;
        end
        if (is_read)
        begin
            rd_b_reg <= mem_b[head.index];
        end
    end

    assign out_valid     = s1_valid_reg;
    assign status        = s1_status_reg;
    assign held_length   = s1_hlen_reg;
    assign frame_pending = s1_pend_reg;
    assign read_data     = s1_read_reg ? (s1_sel_reg ? rd_b_reg : rd_a_reg) : '0;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) < RECV_DEPTH)
        else $error("byte count reached store depth");

    a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> s1_valid_reg && s1_status_reg == ST_ACCEPTED)
        else $error("pending set without accepted frame");

    a_own_flip: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(own_reg) |-> s1_valid_reg && s1_status_reg == ST_ACCEPTED)
        else $error("bank ownership changed without accepted frame");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_ready |-> !pop)
        else $error("executed over a stalled result");

endmodule

### design/xor_checked_frame_receiver.sv
`timescale 1ns / 1ps

// Length-prefixed frame receiver with XOR check.
// Input channel (in_valid/in_ready): each word is a received byte, a release
// of the held frame, a read of one held byte at read_index, or a no-op.
// Output channel (out_valid/out_ready): exactly one result word per input
// word, in order: status, held_length, frame_pending and read_data.
// A 4-word queue sits behind the input; in_ready drops only when it is full,
// so words keep flowing in while a result waits on out_ready.
// An accepted word passes the queue and then the result register to out_valid.
// Throughput: one word per cycle while out_ready does not stall the engine; a
// good frame is handed over by flipping per-byte bank ownership bits, and a
// read uses one registered port of each of the two 256-byte banks.
// A stalled out_ready holds the result register; the engine and queue stop,
// and in_ready falls once four words are queued.
// Reset clears the queue, byte count, pending flag and held length. The byte
// banks are not cleared; reading a held position never written is undefined.
module xor_checked_frame_receiver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [xcfr_pkg::OP_W-1:0]   opcode,
    input  logic [xcfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [7:0]                  read_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [xcfr_pkg::ST_W-1:0]   status,
    output logic [xcfr_pkg::HLEN_W-1:0] held_length,
    output logic                        frame_pending,
    output logic [xcfr_pkg::BYTE_W-1:0] read_data
);
    import xcfr_pkg::*;

    logic head_valid;
    cmd_t head;
    logic pop;

    xcfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    xcfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .held_length   (held_length),
        .frame_pending (frame_pending),
        .read_data     (read_data)
    );

endmodule

### tb/sv/tb_xor_checked_frame_receiver.sv
`timescale 1ns / 1ps

module tb_xor_checked_frame_receiver;
    import xcfr_pkg::*;

    localparam int GEN         = 0;  // shadow copy, steered by stimulus generation
    localparam int CHK         = 1;  // copy that predicts the DUT results
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic [7:0]        index;
    } rx_word_t;

    typedef struct packed {
        status_t           status;
        logic [HLEN_W-1:0] held_length;
        logic              pending;
        logic [BYTE_W-1:0] data;
    } frame_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     opcode = OP_RX;
    logic [BYTE_W-1:0]   rx_byte = '0;
    logic [7:0]          read_index = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ST_W-1:0]     status;
    logic [HLEN_W-1:0]   held_length;
    logic                frame_pending;
    logic [BYTE_W-1:0]   read_data;

    // frame state, two independent copies
    logic [BYTE_W-1:0]   rx_mem   [2][RECV_DEPTH];
    logic [BYTE_W-1:0]   held_mem [2][RECV_DEPTH];
    int unsigned         byte_cnt [2];
    int unsigned         decl_len [2];
    int unsigned         held_cnt [2];
    int unsigned         held_hi  [2];  // held positions [0, held_hi) have been written
    bit                  pend     [2];

    rx_word_t            word_q[$];
    frame_result_t       result_q[$];

    int                  err_count = 0;
    int                  results_seen = 0;
    int                  n_words = 0;
    int                  status_hist[8];
    int unsigned         cycles = 0;

    rx_word_t            cur_word;
    rx_word_t            nxt_word;
    frame_result_t       want;
    logic                drive_next;
    int                  burst_left;
    int                  gap_left;

    logic                ready_next;
    int                  hold_left = 0;
    bit                  hold_done = 0;
    int                  mode_left = 0;
    int                  rdy_mode = 0;

    xor_checked_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .held_length   (held_length),
        .frame_pending (frame_pending),
        .read_data     (read_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic frame_result_t frame_step(int c, rx_word_t w);
        frame_result_t     r;
        status_t           st;
        logic [BYTE_W-1:0] rd;
        logic [BYTE_W-1:0] x;
        int unsigned       pos;
        int unsigned       i;
        st = ST_PROGRESS;
        rd = '0;
        case (w.op)
            OP_RX:
            begin
                pos = byte_cnt[c];
                if (pos >= RECV_DEPTH)
                    pos = 0;
                rx_mem[c][pos] = w.data;
                byte_cnt[c] = pos + 1;
                if (byte_cnt[c] <= 2)
                begin
                    if (w.data != SYNC_BYTE)
                    begin
                        byte_cnt[c] = 0;
                        st = ST_HDR_REJECT;
                    end
                end
                else if (byte_cnt[c] == 5)
                begin
                    decl_len[c] = {rx_mem[c][2], rx_mem[c][3]};
                end
                else if (byte_cnt[c] > 5)
                begin
                    if (byte_cnt[c] > MIN_BYTES_BEFORE_CHECK &&
                        byte_cnt[c] >= decl_len[c] + 3)
                    begin
                        x = '0;
                        for (i = 0; i < decl_len[c]; i++)
                            x ^= rx_mem[c][2 + i];
                        if (x == rx_mem[c][byte_cnt[c] - 1])
                        begin
                            if (!pend[c])
                            begin
                                pend[c] = 1'b1;
                                for (i = 0; i < byte_cnt[c]; i++)
                                    held_mem[c][i] = rx_mem[c][i];
                                held_cnt[c] = byte_cnt[c];
                                if (byte_cnt[c] > held_hi[c])
                                    held_hi[c] = byte_cnt[c];
                                st = ST_ACCEPTED;
                            end
                            else
                                st = ST_DROP_BUSY;
                        end
                        else
                            st = ST_CSUM_BAD;
                        byte_cnt[c] = 0;
                    end
                    if (byte_cnt[c] >= RECV_DEPTH)
                    begin
                        byte_cnt[c] = 0;
                        st = ST_OVERFLOW;
                    end
                end
            end
            OP_RELEASE:
            begin
                pend[c] = 1'b0;
                st = ST_RELEASED;
            end
            OP_READ:
            begin
                if (w.index < RECV_DEPTH)
                    rd = held_mem[c][w.index];
                st = ST_READ;
            end
            default:
                st = ST_PROGRESS;
        endcase
        r.status      = st;
        r.held_length = HLEN_W'(held_cnt[c]);
        r.pending     = pend[c];
        r.data        = rd;
        return r;
    endfunction

    task automatic push_word(logic [OP_W-1:0] op, logic [7:0] b, logic [7:0] idx);
        rx_word_t      w;
        frame_result_t dummy;
        w.op    = op;
        w.data  = b;
        w.index = idx;
        dummy = frame_step(GEN, w);
        word_q.push_back(w);
        n_words++;
    endtask

    task automatic push_byte(logic [7:0] b);
        push_word(OP_RX, b, 8'($urandom));
    endtask

    // reads only positions of the held store that some frame has written, else a NOP
    task automatic push_read();
        if (held_hi[GEN] != 0)
            push_word(OP_READ, 8'($urandom), 8'($urandom_range(0, held_hi[GEN] - 1)));
        else
            push_word(OP_NOP, 8'($urandom), 8'($urandom));
    endtask

    task automatic push_side_op();
        if ($urandom_range(0, 1) == 1)
            push_word(OP_RELEASE, 8'($urandom), 8'($urandom));
        else
            push_read();
    endtask

    // bring the frame counter back to zero before a new frame
    task automatic resync();
        while (byte_cnt[GEN] != 0)
            push_byte(8'h00);
    endtask

    // lengths of 254 and up cannot complete and run into overflow
    task automatic push_frame(logic [15:0] len, bit good, int mix_pct);
        int unsigned n;
        int unsigned i;
        logic [7:0]  b;
        logic [7:0]  x;
        if (len >= 254)
            n = RECV_DEPTH;
        else if (len + 3 < 6)
            n = 6;
        else
            n = len + 3;
        x = '0;
        for (i = 0; i < n; i++)
        begin
            if (mix_pct > 0 && $urandom_range(0, 99) < mix_pct)
                push_side_op();
            if (i < 2)
                b = SYNC_BYTE;
            else if (i == 2)
                b = len[15:8];
            else if (i == 3)
                b = len[7:0];
            else if (i == n - 1 && len < 254)
                b = good ? x : (x ^ 8'($urandom_range(1, 255)));
            else
                b = 8'($urandom);
            if (i >= 2 && i <= len + 1)
                x ^= b;
            push_byte(b);
        end
    endtask

    function automatic logic [15:0] small_len();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 60));
        return 16'($urandom_range(0, 12));
    endfunction

    function automatic logic [7:0] non_sync_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == SYNC_BYTE)
            b = 8'h7F;
        return b;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // sampled away from the rising edge so the driver and monitor have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (word_q.size() != 0 || in_valid || result_q.size() != 0);
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            opcode     <= OP_RX;
            rx_byte    <= '0;
            read_index <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            drive_next = in_valid;
            if (in_valid && in_ready)
            begin
                cur_word.op    = opcode;
                cur_word.data  = rx_byte;
                cur_word.index = read_index;
                result_q.push_back(frame_step(CHK, cur_word));
                drive_next = 1'b0;
            end
            if (!drive_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (word_q.size() > 0)
                begin
                    nxt_word = word_q.pop_front();
                    opcode     <= nxt_word.op;
                    rx_byte    <= nxt_word.data;
                    read_index <= nxt_word.index;
                    drive_next = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            in_valid <= drive_next;
        end
    end

    // receiver: changing stall modes, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                ready_next = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rdy_mode  = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (rdy_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 1) == 1);
                    2: ready_next = ($urandom_range(0, 7) != 0);
                    default: ready_next = ((cycles % 3) != 0);
                endcase
            end
            out_ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (result_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual status %0d",
                         $time, status);
                err_count++;
            end
            else
            begin
                want = result_q.pop_front();
                status_hist[want.status]++;
                check_field("status", 16'(want.status), 16'(status));
                check_field("held_length", 16'(want.held_length), 16'(held_length));
                check_field("frame_pending", 16'(want.pending), 16'(frame_pending));
                check_field("read_data", 16'(want.data), 16'(read_data));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, result_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int c;
        int i;
        int sel;
        int rand_start;
        bit did_max;
        bit did_ovf;

        for (c = 0; c < 2; c++)
        begin
            for (i = 0; i < RECV_DEPTH; i++)
            begin
                rx_mem[c][i]   = '0;
                held_mem[c][i] = '0;
            end
            byte_cnt[c] = 0;
            decl_len[c] = 0;
            held_cnt[c] = 0;
            held_hi[c]  = 0;
            pend[c]     = 1'b0;
        end
        for (i = 0; i < 8; i++)
            status_hist[i] = 0;

        // directed words
        push_word(OP_RELEASE, 8'h00, 8'h00);      // release with nothing held
        push_word(OP_NOP, 8'hFF, 8'hFF);
        push_byte(8'h00);                         // bad first sync
        push_byte(SYNC_BYTE);
        push_byte(8'hFF);                         // bad second sync
        push_frame(16'd4, 1'b1, 0);               // accepted
        push_frame(16'd1, 1'b1, 0);               // good but busy
        push_word(OP_RELEASE, 8'hFF, 8'h00);
        push_frame(16'd0, 1'b1, 0);               // shorter frame accepted
        push_word(OP_READ, 8'h00, 8'd6);          // stale byte past held length
        push_word(OP_READ, 8'hFF, 8'd0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stimulus waits until every directed result is back
        wait_drained();

        // the two long frames count toward the total
        rand_start = n_words;
        did_max = 1'b0;
        did_ovf = 1'b0;
        while (n_words - rand_start < 620 || !did_ovf)
        begin
            if (!did_max && n_words - rand_start >= 120)
            begin
                did_max = 1'b1;
                resync();
                push_word(OP_RELEASE, 8'($urandom), 8'($urandom));
                push_frame(16'd253, 1'b1, 0);     // longest frame that completes
                push_word(OP_READ, 8'($urandom), 8'hFF);
                repeat (6) push_read();
            end
            if (!did_ovf && n_words - rand_start >= 400)
            begin
                did_ovf = 1'b1;
                resync();
                push_frame(16'hFFFF, 1'b1, 0);    // runs into overflow
            end
            sel = $urandom_range(0, 99);
            if (sel < 50)
            begin
                resync();
                push_frame(small_len(), 1'b1, 4);
            end
            else if (sel < 60)
            begin
                resync();
                push_frame(small_len(), 1'b0, 4);
            end
            else if (sel < 66)
            begin
                resync();
                if ($urandom_range(0, 1) == 1)
                    push_byte(non_sync_byte());
                else
                begin
                    push_byte(SYNC_BYTE);
                    push_byte(non_sync_byte());
                end
            end
            else if (sel < 76)
                push_word(OP_RELEASE, 8'($urandom), 8'($urandom));
            else if (sel < 88)
                repeat ($urandom_range(1, 3)) push_read();
            else if (sel < 92)
                push_word(OP_NOP, 8'($urandom), 8'($urandom));
            else
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
        end

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Run covered %0d words: %0d accepted, %0d busy drops, %0d bad checksums,",
                 n_words, status_hist[ST_ACCEPTED], status_hist[ST_DROP_BUSY],
                 status_hist[ST_CSUM_BAD]);
        $display("  %0d header rejects, %0d overflows, %0d releases, %0d reads.",
                 status_hist[ST_HDR_REJECT], status_hist[ST_OVERFLOW],
                 status_hist[ST_RELEASED], status_hist[ST_READ]);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
